// ----- design/swrr_pkg.sv -----
// Shared constants, widths and helpers for the smooth weighted round-robin block.
`timescale 1ns / 1ps

package swrr_pkg;

    localparam int NODES_DEFAULT = 8;
    localparam int REG_COUNT     = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int WEIGHT_W      = 8;
    localparam int RW_W          = 32;
    localparam int WIDE_W        = RW_W + 2;
    localparam int TOTAL_W       = WEIGHT_W + CFG_IDX_W;
    localparam int OUT_IDX_W     = 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1);

    localparam logic signed [WIDE_W-1:0] RW_MAX = WIDE_W'(34'sd2147483647);
    localparam logic signed [WIDE_W-1:0] RW_MIN = -WIDE_W'(34'sd2147483648);

    function automatic logic [RW_W-1:0] sat_rw(input logic signed [WIDE_W-1:0] v);
        logic [RW_W-1:0] r;
        if (v > RW_MAX)
        begin
            r = RW_MAX[RW_W-1:0];
        end
        else if (v < RW_MIN)
        begin
            r = RW_MIN[RW_W-1:0];
        end
        else
        begin
            r = v[RW_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/swrr_cfg.sv -----
// Static weight registers written through the configuration port.
`timescale 1ns / 1ps

module swrr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swrr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swrr_pkg::WEIGHT_W-1:0]       cfg_data,
    output logic [swrr_pkg::WEIGHT_W-1:0]       weight [swrr_pkg::REG_COUNT]
);

    logic [swrr_pkg::WEIGHT_W-1:0] weight_reg [swrr_pkg::REG_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < swrr_pkg::REG_COUNT; i++)
            begin
                weight_reg[i] <= swrr_pkg::WEIGHT_RESET;
            end
        end
        else if (cfg_we)
        begin
            weight_reg[cfg_index] <= cfg_data;
        end
    end

    assign weight = weight_reg;

endmodule

// ----- design/swrr_rw_mem.sv -----
// Running weight memory: one read and one write port, registered read, valid bits for reset.
`timescale 1ns / 1ps

module swrr_rw_mem #(
    parameter int NODES = swrr_pkg::NODES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(NODES)-1:0]      rd_addr,
    output logic [swrr_pkg::RW_W-1:0]     rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(NODES)-1:0]      wr_addr,
    input  logic [swrr_pkg::RW_W-1:0]     wr_data
);

    logic [swrr_pkg::RW_W-1:0] mem [NODES];
    logic [NODES-1:0]          valid_reg;
    logic [swrr_pkg::RW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/smooth_weighted_round_robin.sv -----
// Top level: smooth weighted round-robin node selector over a running weight memory.
// Timing: a request with zero or one eligible node answers in the cycle after start;
//   otherwise it reads every node, writes back each eligible one, then updates the winner.
// One request at a time; busy stays high through the walk and the winner update.
// The result strobe (done) lasts one cycle; the receiver cannot stall.
// Reset: weights to 1, running weights read as zero, controller idle.
`timescale 1ns / 1ps

module smooth_weighted_round_robin #(
    parameter int NODES = swrr_pkg::NODES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [7:0]                        eligible_mask,
    output logic                              done,
    output logic                              found,
    output logic [swrr_pkg::OUT_IDX_W-1:0]    node_index,
    input  logic                              cfg_we,
    input  logic [swrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swrr_pkg::WEIGHT_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(NODES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [swrr_pkg::WEIGHT_W-1:0] weight [swrr_pkg::REG_COUNT];

    logic [NODES-1:0]                 mask_reg, mask_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic                             have_reg, have_next;
    logic [IDX_W-1:0]                 best_idx_reg, best_idx_next;
    logic [swrr_pkg::RW_W-1:0]        best_val_reg, best_val_next;
    logic [swrr_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic                             done_reg, done_next;
    logic                             found_reg, found_next;
    logic [swrr_pkg::OUT_IDX_W-1:0]   node_reg, node_next;

    logic                             rd_en;
    logic [IDX_W-1:0]                 rd_addr;
    logic [swrr_pkg::RW_W-1:0]        rd_data;
    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [swrr_pkg::RW_W-1:0]        wr_data;

    logic [NODES-1:0]                 req_mask;
    logic                             req_multi;
    logic [IDX_W-1:0]                 req_only;
    logic                             accept;
    logic [swrr_pkg::WEIGHT_W-1:0]    cur_weight;
    logic [swrr_pkg::RW_W-1:0]        upd_val;

    swrr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .weight    (weight)
    );

    swrr_rw_mem #(
        .NODES (NODES)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        req_only = '0;
        for (int i = 0; i < NODES; i++)
        begin
            req_mask[i] = eligible_mask[i];
            if (eligible_mask[i])
            begin
                req_only = IDX_W'(i);
            end
        end
        req_multi = ((req_mask & (req_mask - NODES'(1))) != '0);
    end

    assign cur_weight = weight[idx_reg];
    assign upd_val    = swrr_pkg::sat_rw($signed({{2{rd_data[swrr_pkg::RW_W-1]}}, rd_data})
                                         + $signed(swrr_pkg::WIDE_W'(cur_weight)));

    always_comb
    begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        idx_next      = idx_reg;
        have_next     = have_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        total_next    = total_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        node_next     = node_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg + IDX_W'(1);
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = upd_val;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_multi)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        mask_next  = req_mask;
                        idx_next   = '0;
                        have_next  = 1'b0;
                        total_next = '0;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        found_next = (req_mask != '0);
                        node_next  = swrr_pkg::OUT_IDX_W'(req_only);
                    end
                end
            end
            ST_WALK:
            begin
                rd_en = (idx_reg != LAST_IDX);
                if (mask_reg[idx_reg])
                begin
                    wr_en      = 1'b1;
                    total_next = total_reg + swrr_pkg::TOTAL_W'(cur_weight);
                    if (!have_reg || ($signed(upd_val) > $signed(best_val_reg)))
                    begin
                        have_next     = 1'b1;
                        best_idx_next = idx_reg;
                        best_val_next = upd_val;
                    end
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                wr_en      = 1'b1;
                wr_addr    = best_idx_reg;
                wr_data    = swrr_pkg::sat_rw(
                                 $signed({{2{best_val_reg[swrr_pkg::RW_W-1]}}, best_val_reg})
                                 - $signed(swrr_pkg::WIDE_W'(total_reg)));
                done_next  = 1'b1;
                found_next = 1'b1;
                node_next  = swrr_pkg::OUT_IDX_W'(best_idx_reg);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        idx_reg      <= idx_next;
        have_reg     <= have_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        total_reg    <= total_next;
        found_reg    <= found_next;
        node_reg     <= node_next;
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign node_index = node_reg;

endmodule
